@@ design/ekmf_pkg.sv @@
package ekmf_pkg;

  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_CAP_BITS  = 16;

  // fixed field widths of the channels
  localparam int CMD_W     = 2;
  localparam int NODE_W    = 4;
  localparam int ECAP_W    = 16;
  localparam int VALUE_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;
  localparam int NCNT_W    = 5;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = NCNT_W'(16);
  localparam logic [NODE_W-1:0] SOURCE_RST     = NODE_W'(0);
  localparam logic [NODE_W-1:0] SINK_RST       = NODE_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_SOURCE     = 2'd1,
    CFG_SINK       = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_BAD  = 2'd1,
    RES_READ = 2'd2,
    RES_FLOW = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     wipe;
    logic     set_fw;
    logic     set_bw;
    logic     rd_edge;
    logic     copy;
    logic     bfs_init;
    logic     pop;
    logic     scan_rd;
    logic     scan_ev;
    logic     aug_rd;
    logic     aug_fw;
    logic     aug_bw;
    logic     res_ld;
    res_sel_t res_sel;
    logic     out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic bad_edge;
    logic bad_run;
    logic same_node;
    logic queue_empty;
    logic hit;
    logic last_v;
    logic aug_end;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/ekmf_if.sv @@
interface ekmf_in_if import ekmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic [ECAP_W-1:0] edge_cap;
  modport source(output valid, command, from_node, to_node, edge_cap, input ready);
  modport sink(input valid, command, from_node, to_node, edge_cap, output ready);
endinterface

interface ekmf_out_if import ekmf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               status;
  modport source(output valid, value, status, input ready);
  modport sink(input valid, value, status, output ready);
endinterface

interface ekmf_cfg_if import ekmf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ design/ekmf_ctrl.sv @@
module ekmf_ctrl import ekmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  dp_stat_t         stat,
  output ctrl_cmd_t        cmd
);

  typedef enum logic [13:0] {
    S_WIPE     = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_CLEAR    = 14'b00000000000100,
    S_SET2     = 14'b00000000001000,
    S_READ     = 14'b00000000010000,
    S_COPY     = 14'b00000000100000,
    S_BFS_INIT = 14'b00000001000000,
    S_POP      = 14'b00000010000000,
    S_SCAN_RD  = 14'b00000100000000,
    S_SCAN_EV  = 14'b00001000000000,
    S_AUG_RD   = 14'b00010000000000,
    S_AUG_FW   = 14'b00100000000000,
    S_AUG_BW   = 14'b01000000000000,
    S_WB       = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_WIPE: begin
        cmd.wipe = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (cmd_code_t'(in_command))
            CMD_CLEAR: state_nxt = S_CLEAR;
            CMD_SET: begin
              cmd.res_ld = 1'b1;
              if (stat.bad_edge) begin
                cmd.res_sel = RES_BAD;
                state_nxt   = S_WB;
              end else begin
                cmd.set_fw  = 1'b1;
                cmd.res_sel = RES_ZERO;
                state_nxt   = S_SET2;
              end
            end
            CMD_RUN: begin
              if (stat.bad_run) begin
                cmd.res_ld  = 1'b1;
                cmd.res_sel = RES_BAD;
                state_nxt   = S_WB;
              end else begin
                state_nxt = S_COPY;
              end
            end
            CMD_READ: begin
              if (stat.bad_edge) begin
                cmd.res_ld  = 1'b1;
                cmd.res_sel = RES_BAD;
                state_nxt   = S_WB;
              end else begin
                cmd.rd_edge = 1'b1;
                state_nxt   = S_READ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.wipe = 1'b1;
        if (stat.sweep_last) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_ZERO;
          state_nxt   = S_WB;
        end
      end
      S_SET2: begin
        cmd.set_bw = 1'b1;
        state_nxt  = S_WB;
      end
      S_READ: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = RES_READ;
        state_nxt   = S_WB;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.sweep_last) begin
          if (stat.same_node) begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = RES_FLOW;
            state_nxt   = S_WB;
          end else begin
            state_nxt = S_BFS_INIT;
          end
        end
      end
      S_BFS_INIT: begin
        cmd.bfs_init = 1'b1;
        state_nxt    = S_POP;
      end
      S_POP: begin
        if (stat.queue_empty) begin
          // no augmenting path left
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_FLOW;
          state_nxt   = S_WB;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        if (stat.hit)         state_nxt = S_AUG_RD;
        else if (stat.last_v) state_nxt = S_POP;
        else                  state_nxt = S_SCAN_RD;
      end
      S_AUG_RD: begin
        cmd.aug_rd = 1'b1;
        state_nxt  = S_AUG_FW;
      end
      S_AUG_FW: begin
        cmd.aug_fw = 1'b1;
        state_nxt  = S_AUG_BW;
      end
      S_AUG_BW: begin
        cmd.aug_bw = 1'b1;
        state_nxt  = stat.aug_end ? S_BFS_INIT : S_AUG_RD;
      end
      S_WB: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_WIPE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_WIPE;
    else        state_r <= state_nxt;
  end

endmodule

@@ design/ekmf_dp.sv @@
module ekmf_dp import ekmf_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int CAP_BITS  = DEF_CAP_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NODE_W-1:0]    in_from,
  input  logic [NODE_W-1:0]    in_to,
  input  logic [ECAP_W-1:0]    in_cap,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [VALUE_W-1:0]   out_value,
  output logic                 out_status,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int QW    = NW + 1;
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = CAP_BITS + 1;
  localparam int TW    = CAP_BITS + NW + 1;
  localparam int CW    = ($clog2(MAX_NODES + 1) > NCNT_W) ? $clog2(MAX_NODES + 1) : NCNT_W;

  function automatic logic [AW-1:0] pair_addr(input logic [NW-1:0] a, input logic [NW-1:0] b);
    pair_addr = AW'(a) * AW'(MAX_NODES) + AW'(b);
  endfunction

  function automatic logic [VALUE_W-1:0] sat_value(input logic [TW-1:0] x);
    logic [TW+VALUE_W-1:0] wide;
    wide = (TW+VALUE_W)'(x);
    if (wide > (TW+VALUE_W)'(VALUE_MAX)) sat_value = VALUE_MAX;
    else                                 sat_value = wide[VALUE_W-1:0];
  endfunction

  function automatic logic [CAP_BITS-1:0] clamp_cap(input logic [ECAP_W-1:0] c);
    logic [CAP_BITS+ECAP_W-1:0] wide;
    wide = (CAP_BITS+ECAP_W)'(c);
    if (wide > (CAP_BITS+ECAP_W)'({CAP_BITS{1'b1}})) clamp_cap = '1;
    else                                             clamp_cap = wide[CAP_BITS-1:0];
  endfunction

  // configuration
  logic [NCNT_W-1:0] node_count_r;
  logic [NODE_W-1:0] source_r, sink_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      source_r     <= SOURCE_RST;
      sink_r       <= SINK_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NODE_COUNT: node_count_r <= cfg_data[NCNT_W-1:0];
        CFG_SOURCE:     source_r     <= cfg_data[NODE_W-1:0];
        CFG_SINK:       sink_r       <= cfg_data[NODE_W-1:0];
        default:        ;
      endcase
    end
  end

  logic [CW-1:0] n_eff;
  logic [NW-1:0] src_n, snk_n;

  assign n_eff = (CW'(node_count_r) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_r);
  assign src_n = NW'(source_r);
  assign snk_n = NW'(sink_r);

  // memories
  logic [CAP_BITS-1:0] cap_mem [DEPTH];
  logic [RW-1:0]       res_mem [DEPTH];
  logic [CAP_BITS-1:0] cap_rd_r, cap_wd;
  logic [RW-1:0]       res_rd_r, res_wd;
  logic [AW-1:0]       cap_wa, cap_ra, res_wa, res_ra;
  logic                cap_we, res_we;

  // sweep and copy pipeline
  logic [AW-1:0] sweep_r, copy_a_r;
  logic          copy_v_r;
  logic          sweep_last;

  // search state
  logic [MAX_NODES-1:0] visited_r;
  logic [NW-1:0]        parent_r [MAX_NODES];
  logic [NW-1:0]        qn_r     [MAX_NODES];
  logic [RW-1:0]        qb_r     [MAX_NODES];
  logic [QW-1:0]        head_r, tail_r;
  logic [NW-1:0]        u_r, v_r, cur_r, prev_r, from_r, to_r;
  logic [RW-1:0]        bn_r, f_r;
  logic [TW-1:0]        total_r;

  logic [NW-1:0] from_n, to_n, cur_parent;
  logic [RW-1:0] nb, cap_ext, diff;
  logic          take;

  assign from_n     = NW'(in_from);
  assign to_n       = NW'(in_to);
  assign cur_parent = parent_r[cur_r];
  assign sweep_last = (sweep_r == AW'(DEPTH - 1));

  assign take = !visited_r[v_r] && (res_rd_r != '0);
  assign nb   = (res_rd_r < bn_r) ? res_rd_r : bn_r;

  assign cap_ext = RW'(cap_rd_r);
  assign diff    = (cap_ext > res_rd_r) ? cap_ext - res_rd_r : '0;

  always_comb begin
    cap_we = 1'b0;
    cap_wa = sweep_r;
    cap_wd = '0;
    if (cmd.wipe) begin
      cap_we = 1'b1;
    end else if (cmd.set_fw) begin
      cap_we = 1'b1;
      cap_wa = pair_addr(from_n, to_n);
      cap_wd = clamp_cap(in_cap);
    end
    cap_ra = cmd.copy ? sweep_r : pair_addr(from_n, to_n);
  end

  always_comb begin
    res_we = 1'b0;
    res_wa = sweep_r;
    res_wd = '0;
    if (copy_v_r) begin
      res_we = 1'b1;
      res_wa = copy_a_r;
      res_wd = RW'(cap_rd_r);
    end else if (cmd.wipe) begin
      res_we = 1'b1;
    end else if (cmd.set_fw) begin
      res_we = 1'b1;
      res_wa = pair_addr(from_n, to_n);
      res_wd = RW'(clamp_cap(in_cap));
    end else if (cmd.set_bw) begin
      res_we = 1'b1;
      res_wa = pair_addr(to_r, from_r);
    end else if (cmd.aug_fw) begin
      res_we = 1'b1;
      res_wa = pair_addr(prev_r, cur_r);
      res_wd = res_rd_r - f_r;
    end else if (cmd.aug_bw) begin
      res_we = 1'b1;
      res_wa = pair_addr(cur_r, prev_r);
      res_wd = res_rd_r + f_r;
    end
    if (cmd.scan_rd)     res_ra = pair_addr(u_r, v_r);
    else if (cmd.aug_rd) res_ra = pair_addr(cur_parent, cur_r);
    else if (cmd.aug_fw) res_ra = pair_addr(cur_r, prev_r);
    else                 res_ra = pair_addr(from_n, to_n);
  end

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_wa] <= cap_wd;
    cap_rd_r <= cap_mem[cap_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_r <= res_mem[res_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r  <= '0;
      copy_v_r <= 1'b0;
    end else begin
      copy_v_r <= cmd.copy;
      if (cmd.wipe || cmd.copy) sweep_r <= sweep_last ? '0 : sweep_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) visited_r <= '0;
    else if (cmd.bfs_init) begin
      visited_r <= MAX_NODES'(1) << src_n;
    end else if (cmd.scan_ev && take) begin
      visited_r[v_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    copy_a_r <= sweep_r;
    if (cmd.accept) begin
      from_r <= from_n;
      to_r   <= to_n;
    end
    if (cmd.wipe || cmd.copy) total_r <= '0;
    if (cmd.bfs_init) begin
      qn_r[0] <= src_n;
      qb_r[0] <= '1;
      head_r  <= '0;
      tail_r  <= QW'(1);
    end
    if (cmd.pop) begin
      u_r    <= qn_r[head_r[NW-1:0]];
      bn_r   <= qb_r[head_r[NW-1:0]];
      head_r <= head_r + QW'(1);
      v_r    <= '0;
    end
    if (cmd.scan_ev) begin
      v_r <= v_r + NW'(1);
      if (take) begin
        parent_r[v_r] <= u_r;
        if (v_r == snk_n) begin
          f_r     <= nb;
          cur_r   <= snk_n;
          total_r <= total_r + TW'(nb);
        end else if (tail_r < QW'(MAX_NODES)) begin
          qn_r[tail_r[NW-1:0]] <= v_r;
          qb_r[tail_r[NW-1:0]] <= nb;
          tail_r               <= tail_r + QW'(1);
        end
      end
    end
    if (cmd.aug_rd) prev_r <= cur_parent;
    if (cmd.aug_bw) cur_r  <= prev_r;
  end

  // result and output register
  logic [VALUE_W-1:0] res_value_r;
  logic               res_status_r;
  logic               out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        RES_ZERO: begin res_value_r <= '0; res_status_r <= 1'b0; end
        RES_BAD:  begin res_value_r <= '0; res_status_r <= 1'b1; end
        RES_READ: begin res_value_r <= sat_value(TW'(diff)); res_status_r <= 1'b0; end
        RES_FLOW: begin res_value_r <= sat_value(total_r); res_status_r <= 1'b0; end
        default:  begin res_value_r <= '0; res_status_r <= 1'b0; end
      endcase
    end
    if (cmd.out_ld) begin
      out_value  <= res_value_r;
      out_status <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (cmd.out_ld) out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;

  assign stat.sweep_last  = sweep_last;
  assign stat.bad_edge    = (CW'(in_from) >= n_eff) || (CW'(in_to) >= n_eff);
  assign stat.bad_run     = (CW'(source_r) >= n_eff) || (CW'(sink_r) >= n_eff);
  assign stat.same_node   = (source_r == sink_r);
  assign stat.queue_empty = (head_r >= tail_r);
  assign stat.hit         = take && (v_r == snk_n);
  assign stat.last_v      = (CW'(v_r) == n_eff - CW'(1));
  assign stat.aug_end     = (prev_r == src_n);
  assign stat.out_free    = !out_valid_r || out_ready;

endmodule

@@ design/edmonds_karp_max_flow.sv @@
// Clear sweeps MAX_NODES^2 entries; set writes forward then backward residual; a bad
// index goes straight to write-back. Run: accept, residual copy, then per search BFS
// init, a pop per dequeued node, a read and evaluate per scanned neighbor, and a read,
// forward and backward update per path edge. Write-back waits while out is held. One
// request at a time; the next is taken once the result is in the output register.
// Reset: synchronous, active low; a clearing pass over MAX_NODES^2 entries follows.
module edmonds_karp_max_flow import ekmf_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int CAP_BITS  = DEF_CAP_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  ekmf_in_if.sink     in_port,
  ekmf_out_if.source  out_port,
  ekmf_cfg_if.sink    cfg_port
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_port.ready = 1'b1;

  ekmf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_port.valid),
    .in_command (in_port.command),
    .in_ready   (in_port.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ekmf_dp #(
    .MAX_NODES (MAX_NODES),
    .CAP_BITS  (CAP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_from    (in_port.from_node),
    .in_to      (in_port.to_node),
    .in_cap     (in_port.edge_cap),
    .cfg_valid  (cfg_port.valid),
    .cfg_index  (cfg_port.index),
    .cfg_data   (cfg_port.data),
    .out_ready  (out_port.ready),
    .out_valid  (out_port.valid),
    .out_value  (out_port.value),
    .out_status (out_port.status),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

@@ test/ekmf_tb_if.sv @@
`timescale 1ns / 100ps
// Interfaces are provided by the design's ekmf_if.sv; this file carries the
// request and result types used by the checker.
package ekmf_tb_pkg;
  import ekmf_pkg::*;

  typedef struct packed {
    cmd_code_t         command;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [ECAP_W-1:0] edge_cap;
  } flow_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } flow_res_t;
endpackage

@@ test/ekmf_checker.sv @@
`timescale 1ns / 100ps
module ekmf_checker import ekmf_pkg::*; import ekmf_tb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ekmf_in_if   in_mon,
  ekmf_out_if  out_mon,
  ekmf_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);
  localparam int N = DEF_MAX_NODES;

  logic [15:0] cap_mx [N][N];
  logic [16:0] resid_mx [N][N];
  logic [4:0]  node_cnt;
  logic [3:0]  src_node, snk_node;
  flow_res_t   expected_q[$];

  // one BFS; returns bottleneck or 0, fills parent
  function automatic logic [16:0] find_path(int n, int s, int t, ref int par[N]);
    bit seen[N];
    int qn[$];
    logic [17:0] qb[$];
    int u;
    logic [17:0] bn, nb;
    foreach (seen[i]) seen[i] = 0;
    seen[s] = 1;
    qn = {qn, s};
    qb = {qb, 18'h3ffff};
    while (qn.size() > 0) begin
      u = qn.pop_front();
      bn = qb.pop_front();
      for (int v = 0; v < n; v++) begin
        if (!seen[v] && resid_mx[u][v] != 0) begin
          nb = (resid_mx[u][v] < bn) ? resid_mx[u][v] : bn;
          seen[v] = 1;
          par[v] = u;
          if (v == t) return nb[16:0];
          qn = {qn, v};
          qb = {qb, nb};
        end
      end
    end
    return 0;
  endfunction

  function automatic flow_res_t predict_flow(flow_req_t r);
    flow_res_t res;
    int n, f, cur, prv;
    int par[N];
    longint total;
    res = '0;
    n = (node_cnt > N) ? N : node_cnt;
    case (r.command)
      CMD_CLEAR: begin
        foreach (cap_mx[i, j]) begin
          cap_mx[i][j] = 0;
          resid_mx[i][j] = 0;
        end
      end
      CMD_SET, CMD_READ: begin
        if (r.from_node >= n || r.to_node >= n) res.status = 1;
        else if (r.command == CMD_SET) begin
          cap_mx[r.from_node][r.to_node] = r.edge_cap;
          resid_mx[r.from_node][r.to_node] = r.edge_cap;
          resid_mx[r.to_node][r.from_node] = 0;
        end else if (cap_mx[r.from_node][r.to_node] > resid_mx[r.from_node][r.to_node])
          res.value = cap_mx[r.from_node][r.to_node] - resid_mx[r.from_node][r.to_node];
      end
      default: begin
        if (src_node >= n || snk_node >= n) res.status = 1;
        else begin
          foreach (cap_mx[i, j]) resid_mx[i][j] = cap_mx[i][j];
          total = 0;
          if (src_node != snk_node) begin
            f = find_path(n, src_node, snk_node, par);
            while (f != 0) begin
              total += f;
              cur = snk_node;
              while (cur != src_node) begin
                prv = par[cur];
                resid_mx[prv][cur] -= f;
                resid_mx[cur][prv] += f;
                cur = prv;
              end
              f = find_path(n, src_node, snk_node, par);
            end
          end
          res.value = (total > VALUE_MAX) ? VALUE_MAX : total[VALUE_W-1:0];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    flow_req_t req;
    flow_res_t exp_res;
    if (!rst_n) begin
      foreach (cap_mx[i, j]) begin
        cap_mx[i][j] = 0;
        resid_mx[i][j] = 0;
      end
      node_cnt = NODE_COUNT_RST;
      src_node = SOURCE_RST;
      snk_node = SINK_RST;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_NODE_COUNT: node_cnt = cfg_mon.data;
          CFG_SOURCE:     src_node = cfg_mon.data[3:0];
          CFG_SINK:       snk_node = cfg_mon.data[3:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending: value=%0d status=%0d",
                 out_mon.value, out_mon.status);
          fail_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_mon.value !== exp_res.value) begin
            $error("value: expected %0d actual %0d", exp_res.value, out_mon.value);
            fail_count++;
          end
          if (out_mon.status !== exp_res.status) begin
            $error("status: expected %0d actual %0d", exp_res.status, out_mon.status);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req.command   = cmd_code_t'(in_mon.command);
        req.from_node = in_mon.from_node;
        req.to_node   = in_mon.to_node;
        req.edge_cap  = in_mon.edge_cap;
        expected_q = {expected_q, predict_flow(req)};
      end
    end
    pending_count = expected_q.size();
  end
endmodule

@@ test/edmonds_karp_max_flow_test.sv @@
`timescale 1ns / 100ps
module edmonds_karp_max_flow_test;
  import ekmf_pkg::*;
  import ekmf_tb_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, pending_count;
  int   cur_nodes;
  bit   sink_stall_en;

  ekmf_in_if  in_ch();
  ekmf_out_if out_ch();
  ekmf_cfg_if cfg_ch();

  edmonds_karp_max_flow u_top (
    .clk(clk), .rst_n(rst_n),
    .in_port(in_ch.sink), .out_port(out_ch.source), .cfg_port(cfg_ch.sink)
  );

  ekmf_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure
  initial begin
    int g;
    out_ch.ready = 0;
    @(posedge clk);
    forever begin
      if (sink_stall_en) g = gap_len(); else g = 0;
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_request(cmd_code_t c, int f, int t, int capv);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid     <= 1;
    in_ch.command   <= c;
    in_ch.from_node <= f[NODE_W-1:0];
    in_ch.to_node   <= t[NODE_W-1:0];
    in_ch.edge_cap  <= capv[ECAP_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, int d);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d[CFG_DAT_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  task automatic drain_idle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int n, int s, int t);
    drain_idle();
    write_reg(CFG_NODE_COUNT, n);
    write_reg(CFG_SOURCE, s);
    write_reg(CFG_SINK, t);
    cur_nodes = (n > DEF_MAX_NODES) ? DEF_MAX_NODES : n;
  endtask

  function automatic int rand_cap();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'hffff;
    if (p < 3) return $urandom_range(0, 65535);
    return $urandom_range(1, 20);
  endfunction

  // random graph build then run, readback and an occasional random command
  task automatic flow_burst(int edges);
    int n;
    n = cur_nodes;
    send_request(CMD_CLEAR, $urandom, $urandom, $urandom);
    repeat (edges) begin
      if ($urandom_range(0, 19) == 0)
        send_request(CMD_SET, $urandom_range(0, 15), $urandom_range(0, 15), rand_cap());
      else
        send_request(CMD_SET, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     rand_cap());
    end
    send_request(CMD_RUN, $urandom, $urandom, $urandom);
    repeat ($urandom_range(1, 4))
      send_request(CMD_READ, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
    if ($urandom_range(0, 9) == 0)
      send_request(cmd_code_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
  endtask

  initial begin
    int sent, n;
    sink_stall_en = 1;
    rst_n = 0;
    in_ch.valid = 0; in_ch.command = CMD_CLEAR; in_ch.from_node = 0;
    in_ch.to_node = 0; in_ch.edge_cap = 0;
    cfg_ch.valid = 0; cfg_ch.index = CFG_NODE_COUNT; cfg_ch.data = 0;
    cur_nodes = DEF_MAX_NODES;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: chain 0->2->1 plus direct edge, extremes, bad indices
    send_request(CMD_RUN, 0, 0, 0);
    send_request(CMD_SET, 0, 2, 16'hffff);
    send_request(CMD_SET, 2, 1, 16'hffff);
    send_request(CMD_SET, 0, 1, 16'hffff);
    send_request(CMD_SET, 0, 1, 5);           // overwrite
    send_request(CMD_SET, 3, 3, 7);           // self loop
    send_request(CMD_SET, 15, 15, 0);
    send_request(CMD_RUN, 0, 0, 0);
    send_request(CMD_READ, 0, 2, 0);
    send_request(CMD_READ, 0, 1, 0);
    send_request(CMD_READ, 2, 0, 0);
    send_request(CMD_READ, 15, 15, 0);
    set_config(2, 0, 1);
    send_request(CMD_SET, 2, 0, 3);           // bad from
    send_request(CMD_SET, 0, 15, 3);          // bad to
    send_request(CMD_READ, 15, 0, 0);
    send_request(CMD_RUN, 0, 0, 0);
    set_config(2, 1, 1);
    send_request(CMD_RUN, 0, 0, 0);           // source equals sink
    set_config(4, 0, 15);
    send_request(CMD_RUN, 0, 0, 0);           // bad sink
    send_request(CMD_CLEAR, 15, 15, 16'hffff);
    send_request(CMD_READ, 0, 2, 0);
    set_config(31, 15, 0);                    // count above max acts as max

    // random phases
    sent = 0;
    while (sent < 1500) begin
      if ($urandom_range(0, 5) == 0) begin
        n = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 2 : 16)
                                       : $urandom_range(2, 16);
        set_config($urandom_range(0, 7) == 0 ? $urandom_range(17, 31) : n,
                   $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(0, n - 1),
                   $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(0, n - 1));
        sink_stall_en = ($urandom_range(0, 3) != 0);
      end
      n = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 12);
      flow_burst(n);
      sent += n + 4;
    end

    drain_idle();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ filelist.f @@
design/ekmf_pkg.sv
design/ekmf_if.sv
design/ekmf_ctrl.sv
design/ekmf_dp.sv
design/edmonds_karp_max_flow.sv
test/ekmf_tb_if.sv
test/ekmf_checker.sv
test/edmonds_karp_max_flow_test.sv
